FILE: hw/rtl/vwh_pkg.sv
// Shared constants, types and a helper function for the vertex weld hash block.
package vwh_pkg;

    // Slot table depth; a power of two, so the home slot is the low hash bits.
    localparam int SLOTS      = 4096;
    localparam int MAX_VERTS  = 2048;

    localparam int POS_W      = $clog2(SLOTS);
    localparam int VADDR_W    = $clog2(MAX_VERTS);
    // A slot holds the stored index plus one, so zero can mean empty.
    localparam int ENTRY_W    = $clog2(MAX_VERTS + 1);
    localparam int IDX_W      = 11;
    localparam int COORD_W    = 32;
    localparam int VERT_W     = 3 * COORD_W;

    localparam int FNV_BYTES  = VERT_W / 8;
    localparam int BYTE_CNT_W = $clog2(FNV_BYTES);

    localparam logic [COORD_W-1:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [COORD_W-1:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [COORD_W-1:0] NEG_ZERO  = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_CHK,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OUT_MATCH  = 2'd0,
        OUT_APPEND = 2'd1,
        OUT_REJECT = 2'd2
    } outcome_t;

    // Negative zero becomes positive zero; every other pattern passes as is.
    function automatic logic [COORD_W-1:0] fold_zero(input logic [COORD_W-1:0] bits);
        logic [COORD_W-1:0] res;
        res = (bits == NEG_ZERO) ? '0 : bits;
        return res;
    endfunction

endpackage

FILE: hw/rtl/vwh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module vwh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/vwh_fnv.sv
// Byte-serial FNV-1a hash unit: one byte and one multiply by the prime per cycle.
module vwh_fnv
    import vwh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VERT_W-1:0]  data,
    output logic               done,
    output logic [COORD_W-1:0] hash
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [BYTE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [COORD_W-1:0]    h_reg, h_next;
    logic [VERT_W-1:0]     data_reg, data_next;
    logic [COORD_W-1:0]    mix;
    logic                  last_byte;

    // The word is shifted right, so bytes leave x first, low byte first.
    assign mix       = h_reg ^ {{(COORD_W-8){1'b0}}, data_reg[7:0]};
    assign last_byte = (cnt_reg == BYTE_CNT_W'(FNV_BYTES - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        h_next    = h_reg;
        data_next = data_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            h_next    = FNV_BASIS;
            data_next = data;
        end
        else if (busy_reg)
        begin
            h_next    = mix * FNV_PRIME;
            data_next = data_reg >> 8;
            cnt_next  = cnt_reg + 1'b1;
            if (last_byte)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        data_reg <= data_next;
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

FILE: hw/rtl/vertex_weld_hash_core.sv
// Each vertex is hashed, then probed from its home slot: an empty slot ends the walk with an
// append (or a reject if the store is full), a stored match with a weld, and each occupied
// non-matching slot adds a probe. One vertex is worked on at a time; the next is taken once
// its result enters the output register. The 12 hash steps go through one shared multiplier;
// each probe takes one slot RAM read and one vertex store read on the registered RAM ports.
// After reset a clearing pass zeroes the slot table, and in_ready stays low until it ends.
module vertex_weld_hash_core
    import vwh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] coord_x,
    input  logic [COORD_W-1:0] coord_y,
    input  logic [COORD_W-1:0] coord_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [IDX_W-1:0]   vertex_index,
    output logic [1:0]         outcome
);

    state_t              state_reg, state_next;
    logic [VERT_W-1:0]   coord_reg, coord_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    probe_reg, probe_next;
    logic [POS_W-1:0]    clr_reg, clr_next;
    logic [ENTRY_W-1:0]  count_reg, count_next;
    logic [ENTRY_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    outcome_t            res_code_reg, res_code_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_idx_reg, out_idx_next;
    outcome_t            out_code_reg, out_code_next;

    logic                in_fire;
    logic [VERT_W-1:0]   folded;
    logic                fnv_done;
    logic [COORD_W-1:0]  fnv_hash;

    logic                slot_we;
    logic [POS_W-1:0]    slot_waddr;
    logic [ENTRY_W-1:0]  slot_wdata;
    logic [POS_W-1:0]    slot_raddr;
    logic [ENTRY_W-1:0]  slot_rdata;
    logic                st_we;
    logic [VADDR_W-1:0]  st_raddr;
    logic [VERT_W-1:0]   st_rdata;
    logic [ENTRY_W-1:0]  entry_k;

    logic                slot_empty;
    logic                store_full;
    logic                vert_match;
    logic                last_probe;
    logic                clr_last;
    logic                out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Coordinates are canonicalized on entry; hash and compare both use the folded word.
    assign folded = {fold_zero(coord_z), fold_zero(coord_y), fold_zero(coord_x)};

    vwh_fnv u_fnv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire),
        .data  (folded),
        .done  (fnv_done),
        .hash  (fnv_hash)
    );

    vwh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    vwh_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTS)
    ) u_store_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (count_reg[VADDR_W-1:0]),
        .wdata (coord_reg),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign slot_empty = (slot_rdata == '0);
    assign entry_k    = slot_rdata - 1'b1;
    assign store_full = (count_reg >= ENTRY_W'(MAX_VERTS));
    assign vert_match = (st_rdata == coord_reg);
    assign last_probe = (probe_reg == POS_W'(SLOTS - 1));
    assign clr_last   = (clr_reg == POS_W'(SLOTS - 1));
    assign out_free   = !out_valid_reg || out_ready;

    // The slot read is issued ahead of ST_CHK: from the fresh hash while hashing, and at the next
    // slot while the stored vertex is being compared, so each miss costs one ST_CHK and one ST_CMP.
    assign slot_raddr = (state_reg == ST_CMP) ? (pos_reg + 1'b1) : fnv_hash[POS_W-1:0];
    assign st_raddr   = entry_k[VADDR_W-1:0];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (fnv_done)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                state_next = slot_empty ? ST_DONE : ST_CMP;
            end
            ST_CMP:
            begin
                state_next = (vert_match || last_probe) ? ST_DONE : ST_CHK;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        coord_next    = coord_reg;
        pos_next      = pos_reg;
        probe_next    = probe_reg;
        clr_next      = clr_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        res_idx_next  = res_idx_reg;
        res_code_next = res_code_reg;
        slot_we       = 1'b0;
        slot_waddr    = pos_reg;
        slot_wdata    = count_reg + 1'b1;
        st_we         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                clr_next   = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    coord_next = folded;
                end
            end
            ST_HASH:
            begin
                if (fnv_done)
                begin
                    pos_next   = fnv_hash[POS_W-1:0];
                    probe_next = '0;
                end
            end
            ST_CHK:
            begin
                if (slot_empty)
                begin
                    if (store_full)
                    begin
                        res_idx_next  = '0;
                        res_code_next = OUT_REJECT;
                    end
                    else
                    begin
                        slot_we       = 1'b1;
                        st_we         = 1'b1;
                        count_next    = count_reg + 1'b1;
                        res_idx_next  = IDX_W'(count_reg);
                        res_code_next = OUT_APPEND;
                    end
                end
                else
                begin
                    k_next = entry_k;
                end
            end
            ST_CMP:
            begin
                if (vert_match)
                begin
                    res_idx_next  = IDX_W'(k_reg);
                    res_code_next = OUT_MATCH;
                end
                else if (last_probe)
                begin
                    res_idx_next  = '0;
                    res_code_next = OUT_REJECT;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register: a finished result waits here until it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_code_next  = out_code_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = res_idx_reg;
            out_code_next  = res_code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            probe_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            probe_reg     <= probe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coord_reg    <= coord_next;
        pos_reg      <= pos_next;
        k_reg        <= k_next;
        res_idx_reg  <= res_idx_next;
        res_code_reg <= res_code_next;
        out_idx_reg  <= out_idx_next;
        out_code_reg <= out_code_next;
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_idx_reg;
    assign outcome      = out_code_reg;

endmodule

FILE: hw/rtl/vwh_checker.sv
// Port-level checker for the vertex weld hash core, with its bind statement.
module vwh_checker
    import vwh_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [IDX_W-1:0]   vertex_index,
    input logic [1:0]         outcome
);

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vertex_index) && $stable(outcome))
        else $error("result word changed while stalled");

    // A result word only leaves through a handshake.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result word dropped without handshake");

    // The block works on one vertex at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a vertex is in progress");

    // Only the three defined outcome codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outcome == OUT_MATCH || outcome == OUT_APPEND || outcome == OUT_REJECT))
        else $error("undefined outcome code");

    // A rejected vertex reports index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OUT_REJECT) |-> (vertex_index == '0))
        else $error("rejected vertex with nonzero index");

endmodule

bind vertex_weld_hash_core vwh_checker u_vwh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex_index (vertex_index),
    .outcome      (outcome)
);

FILE: tb/tb.sv
// Self-checking testbench for the vertex weld hash core.
`timescale 1ns / 1ps

module tb;
    import vwh_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DIR_ROWS    = 21;

    // One vertex as the three raw coordinate bit patterns, x first.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } vertex_t;

    // One result word. The known flag marks a directed row whose answer is typed in.
    typedef struct packed {
        logic             known;
        logic [IDX_W-1:0] vidx;
        outcome_t         result;
    } answer_t;

    typedef struct packed {
        vertex_t v;
        answer_t ans;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic               out_valid;
    logic               out_ready;
    logic [IDX_W-1:0]   vertex_index;
    logic [1:0]         outcome;

    vertex_weld_hash_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_index (vertex_index),
        .outcome      (outcome)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the block's state: the slot table holds the stored index
    // plus one (zero means empty), the store holds canonical vertices.
    int unsigned slot_map [SLOTS];
    vertex_t     weld_store [MAX_VERTS];
    int unsigned stored_total = 0;
    int unsigned longest_chain = 0;

    answer_t     weld_expect_q [$];
    answer_t     known_answer_q [$];
    vertex_t     sent_vertices [$];

    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sent_total = 0;
    int unsigned seen_match = 0;
    int unsigned seen_append = 0;
    int unsigned seen_reject = 0;

    // Idle rates in percent, and a long receiver hold-off handed to the receiver process.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_req_cycles = 0;

    // Directed words. Most answers can be read straight off the rules: the first
    // vertex after reset lands at index zero, negative zero welds onto positive zero,
    // and NaNs weld only when their bits agree. The last rows go through the predictor.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, '{1'b1, 11'd0, OUT_APPEND}},
        '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, '{1'b1, 11'd0, OUT_MATCH}},
        '{'{32'h8000_0000, 32'h0000_0000, 32'h0000_0000}, '{1'b1, 11'd0, OUT_MATCH}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '{1'b1, 11'd1, OUT_APPEND}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '{1'b1, 11'd1, OUT_MATCH}},
        '{'{32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000}, '{1'b1, 11'd2, OUT_APPEND}},
        '{'{32'hFFC0_0000, 32'h7FC0_0000, 32'h7FC0_0000}, '{1'b1, 11'd3, OUT_APPEND}},
        '{'{32'h7F80_0001, 32'h0000_0000, 32'h8000_0000}, '{1'b1, 11'd4, OUT_APPEND}},
        '{'{32'h7F80_0001, 32'h8000_0000, 32'h0000_0000}, '{1'b1, 11'd4, OUT_MATCH}},
        '{'{32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000}, '{1'b1, 11'd2, OUT_MATCH}},
        '{'{32'h0000_0001, 32'h0000_0000, 32'h0000_0000}, '{1'b1, 11'd5, OUT_APPEND}},
        '{'{32'h8000_0001, 32'h0000_0000, 32'h0000_0000}, '{1'b1, 11'd6, OUT_APPEND}},
        '{'{32'h0000_0000, 32'h0000_0000, 32'h8000_0001}, '{1'b1, 11'd7, OUT_APPEND}},
        '{'{32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000}, '{1'b1, 11'd8, OUT_APPEND}},
        '{'{32'h3F80_0000, 32'hBF80_0000, 32'hFF80_0000}, '{1'b1, 11'd9, OUT_APPEND}},
        '{'{32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000}, '{1'b1, 11'd8, OUT_MATCH}},
        '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, '{1'b0, 11'd0, OUT_REJECT}},
        '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, '{1'b0, 11'd0, OUT_REJECT}},
        '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0001}, '{1'b0, 11'd0, OUT_REJECT}},
        '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, '{1'b0, 11'd0, OUT_REJECT}},
        '{'{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF}, '{1'b0, 11'd0, OUT_REJECT}}
    };

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Predicts the answer for one vertex and updates the shadow state. Negative
    // zero is folded first, then the 12 bytes are hashed low byte first, x to z.
    // The probe walks forward from the home slot until it finds the vertex or a
    // hole. A full slot table cannot occur here since there are more slots than
    // store entries, but the walk is bounded the same way regardless.
    task automatic weld_lookup(input vertex_t raw, output answer_t ans);
        vertex_t            v;
        logic [VERT_W-1:0]  bytes_lo_first;
        logic [COORD_W-1:0] h;
        int unsigned        pos;
        int unsigned        entry;
        int unsigned        probes;
        v.x = (raw.x == NEG_ZERO) ? '0 : raw.x;
        v.y = (raw.y == NEG_ZERO) ? '0 : raw.y;
        v.z = (raw.z == NEG_ZERO) ? '0 : raw.z;
        bytes_lo_first = {v.z, v.y, v.x};
        h = FNV_BASIS;
        for (int i = 0; i < FNV_BYTES; i++)
        begin
            h = (h ^ {24'd0, bytes_lo_first[8*i +: 8]}) * FNV_PRIME;
        end
        pos = h % SLOTS;
        ans = '{1'b0, '0, OUT_REJECT};
        for (probes = 0; probes < SLOTS; probes++)
        begin
            entry = slot_map[pos];
            if (entry == 0)
            begin
                // A hole ends the walk; the vertex goes in only if the store has room.
                if (stored_total < MAX_VERTS)
                begin
                    weld_store[stored_total] = v;
                    slot_map[pos] = stored_total + 1;
                    ans.vidx = IDX_W'(stored_total);
                    ans.result = OUT_APPEND;
                    stored_total++;
                end
                break;
            end
            else if (weld_store[entry - 1] == v)
            begin
                ans.vidx = IDX_W'(entry - 1);
                ans.result = OUT_MATCH;
                break;
            end
            pos = (pos + 1) % SLOTS;
        end
        if (probes + 1 > longest_chain)
            longest_chain = probes + 1;
    endtask

    // Random coordinate, biased toward the patterns with special meaning.
    function automatic logic [COORD_W-1:0] pick_coord();
        logic [COORD_W-1:0] c;
        case ($urandom_range(15))
            0:       c = '0;
            1:       c = NEG_ZERO;
            2:       c = 32'h7FC0_0000 | ($urandom() & 32'h803F_FFFF);
            3:       c = '1;
            default: c = $urandom();
        endcase
        return c;
    endfunction

    function automatic vertex_t fresh_vertex();
        vertex_t v;
        v.x = pick_coord();
        v.y = pick_coord();
        v.z = pick_coord();
        return v;
    endfunction

    // Flips the sign of a zero coordinate half the time, so a repeated vertex
    // still has to weld through the negative zero fold.
    function automatic logic [COORD_W-1:0] toggle_zero_sign(input logic [COORD_W-1:0] c);
        if ((c & ~NEG_ZERO) == '0 && $urandom_range(1) == 1)
            return c ^ NEG_ZERO;
        return c;
    endfunction

    // Offers one word and returns at the edge where it is taken. Valid stays high
    // into the next word unless the sender decides to idle first.
    task automatic drive_vertex(input vertex_t v, input answer_t typed);
        known_answer_q.push_back(typed);
        sent_vertices.push_back(v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coord_x  <= v.x;
        coord_y  <= v.y;
        coord_z  <= v.z;
        do
            @(posedge clk);
        while (!in_ready);
        sent_total++;
    endtask

    // Random mix: repeats of earlier vertices (which should weld), near misses
    // with one bit flipped, and fresh vertices.
    task automatic run_mixed(input int unsigned count);
        vertex_t     v;
        int unsigned pick;
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                v = sent_vertices[$urandom_range(sent_vertices.size() - 1)];
                v.x = toggle_zero_sign(v.x);
                v.y = toggle_zero_sign(v.y);
                v.z = toggle_zero_sign(v.z);
            end
            else if (pick < 55)
            begin
                v = sent_vertices[$urandom_range(sent_vertices.size() - 1)];
                v = v ^ (96'd1 << $urandom_range(VERT_W - 1));
            end
            else
            begin
                v = fresh_vertex();
            end
            drive_vertex(v, '{1'b0, '0, OUT_REJECT});
        end
    endtask

    // Watches both handshakes. Inputs change only on nonblocking updates at the
    // edge, so the values seen here are the ones the block sampled.
    always @(posedge clk)
    begin : watch
        answer_t predicted;
        answer_t typed;
        answer_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                weld_lookup('{coord_x, coord_y, coord_z}, predicted);
                typed = known_answer_q.pop_front();
                weld_expect_q.push_back(typed.known ? typed : predicted);
            end
            if (out_valid && out_ready)
            begin
                case (outcome)
                    OUT_MATCH:  seen_match++;
                    OUT_APPEND: seen_append++;
                    default:    seen_reject++;
                endcase
                if (weld_expect_q.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected word: index %0d outcome %0d",
                                            vertex_index, outcome));
                end
                else
                begin
                    want = weld_expect_q.pop_front();
                    if (vertex_index !== want.vidx)
                        flag_mismatch($sformatf("vertex_index %0d, expected %0d",
                                                vertex_index, want.vidx));
                    if (outcome !== want.result)
                        flag_mismatch($sformatf("outcome %0d, expected %0d (%s)",
                                                outcome, want.result, want.result.name()));
                end
            end
        end
    end

    // Receiver: random stalls at the current rate, or a long hold-off on request.
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req_cycles != 0)
            begin
                hold_left = hold_req_cycles;
                hold_req_cycles = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog. The limit covers the slot table clearing pass and many times the
    // slowest expected run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d words outstanding.",
                     cycle_count, weld_expect_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n    = 1'b0;
        in_valid = 1'b0;
        coord_x  = '0;
        coord_y  = '0;
        coord_z  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Sender mostly busy, receiver mostly stalled. The first word also waits
        // out the clearing pass, since in_ready stays low until it ends.
        send_idle_pct = 11;
        recv_idle_pct = 87;
        for (int r = 0; r < DIR_ROWS; r++)
            drive_vertex(dir_rows[r].v, dir_rows[r].ans);
        run_mixed(420);

        // Roles swapped: sparse input, eager receiver.
        send_idle_pct = 87;
        recv_idle_pct = 11;
        run_mixed(420);

        // No idling at all. Right at the start the receiver holds off for a long
        // stretch, so the word in flight backs up and the block stops taking input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req_cycles = 400;
        run_mixed(410);
        in_valid <= 1'b0;

        // One edge so the last accepted word is on the queue, then drain and
        // leave room for any stray word.
        @(posedge clk);
        while (weld_expect_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Sent %0d vertices: %0d welded, %0d appended, %0d rejected.",
                 sent_total, seen_match, seen_append, seen_reject);
        $display("Store held %0d of %0d vertices; longest probe run was %0d slots.",
                 stored_total, MAX_VERTS, longest_chain);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/vwh_pkg.sv
hw/rtl/vwh_ram.sv
hw/rtl/vwh_fnv.sv
hw/rtl/vertex_weld_hash_core.sv
hw/rtl/vwh_checker.sv
tb/tb.sv
